@@ hdl/bres_pkg.sv @@
// Shared types and constants for the Bresenham line pixel generator.
`default_nettype none

package bres_pkg;

   localparam int COORD_BITS = 16;
   localparam int FIELD_BITS = 16;
   localparam int ERR_BITS   = COORD_BITS + 3;

   localparam logic OP_START = 1'b0;
   localparam logic OP_NEXT  = 1'b1;

   typedef struct packed {
      logic                  op;
      logic [FIELD_BITS-1:0] x_start;
      logic [FIELD_BITS-1:0] y_start;
      logic [FIELD_BITS-1:0] x_end;
      logic [FIELD_BITS-1:0] y_end;
      logic [FIELD_BITS-1:0] color;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] pixel_x;
      logic [FIELD_BITS-1:0] pixel_y;
      logic [FIELD_BITS-1:0] pixel_color;
      logic                  last;
   } rsp_type;

   // Walk state of one line: position, error term, count and step setup.
   typedef struct packed {
      logic [COORD_BITS-1:0]      cur_x;
      logic [COORD_BITS-1:0]      cur_y;
      logic signed [ERR_BITS-1:0] err_acc;
      logic [COORD_BITS-1:0]      pixels_left;
      logic                       x_negative;
      logic                       y_negative;
      logic                       y_major;
      logic [COORD_BITS:0]        twice_dx;
      logic [COORD_BITS:0]        twice_dy;
   } line_type;

endpackage

`default_nettype wire

@@ hdl/bresenham_line_pixel_generator.sv @@
// Bresenham line rasterizer: at most one pixel per request, two-stage pipeline.
//
// Requests arrive on req_valid/req_ready with a req_type payload. A start
// request (op = OP_START) carries both endpoints and a color and produces the
// first pixel of the line; each next request (op = OP_NEXT) produces the
// following pixel. The final pixel carries last = 1. A next request with no
// line in progress is consumed and produces no pixel. A start request drops
// any line in progress.
// Pixels leave on rsp_valid/rsp_ready with a rsp_type payload.
// An accepted request is registered in the request stage (with its line
// setup), then its pixel is registered in the pixel stage (with the walk step).
// Throughput: one request per cycle while rsp_ready stays high; the step
// loop closes through one add-and-compare in the pixel stage.
// When the receiver stalls, the finished pixel holds in the output register
// and one further request is still taken into the request stage.
// Reset (synchronous, active high) empties both stages and ends any line.
`default_nettype none

module bresenham_line_pixel_generator (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire bres_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output bres_pkg::rsp_type  rsp_payload
);
   import bres_pkg::*;

   logic      s1_valid_ff, s1_valid_in;
   logic      s1_op_ff, s1_op_in;
   logic [FIELD_BITS-1:0] s1_color_ff, s1_color_in;
   line_type  s1_line_ff, s1_line_in;

   line_type  line_ff, line_in;
   logic [FIELD_BITS-1:0] color_ff, color_in;
   logic      active_ff, active_in;

   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;

   line_type  setup_line;
   line_type  step_cur;
   line_type  step_nxt;
   logic      step_last;
   logic      advance;
   logic      req_fire;
   logic      is_start;
   logic      emit;
   logic [FIELD_BITS-1:0] emit_color;

   bres_setup u_setup (
      .x0   (req_payload.x_start[COORD_BITS-1:0]),
      .y0   (req_payload.y_start[COORD_BITS-1:0]),
      .x1   (req_payload.x_end[COORD_BITS-1:0]),
      .y1   (req_payload.y_end[COORD_BITS-1:0]),
      .line (setup_line)
   );

   bres_step u_step (
      .cur  (step_cur),
      .nxt  (step_nxt),
      .last (step_last)
   );

   always_comb begin
      advance    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready  = !s1_valid_ff || advance;
      req_fire   = req_valid && req_ready;
      is_start   = (s1_op_ff == OP_START);
      emit       = is_start || active_ff;
      step_cur   = is_start ? s1_line_ff : line_ff;
      emit_color = is_start ? s1_color_ff : color_ff;
   end

   // request stage
   always_comb begin
      s1_valid_in = req_ready ? req_valid : s1_valid_ff;
      s1_op_in    = s1_op_ff;
      s1_color_in = s1_color_ff;
      s1_line_in  = s1_line_ff;
      if (req_fire) begin
         s1_op_in    = req_payload.op;
         s1_color_in = req_payload.color;
         s1_line_in  = setup_line;
      end
   end

   // line state and pixel stage
   always_comb begin
      line_in   = line_ff;
      color_in  = color_ff;
      active_in = active_ff;
      rsp_in    = rsp_ff;
      if (advance && emit) begin
         line_in            = step_nxt;
         color_in           = emit_color;
         active_in          = !step_last;
         rsp_in.pixel_x     = FIELD_BITS'(step_cur.cur_x);
         rsp_in.pixel_y     = FIELD_BITS'(step_cur.cur_y);
         rsp_in.pixel_color = emit_color;
         rsp_in.last        = step_last;
      end
      priority if (advance) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         line_ff      <= '0;
         color_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         line_ff      <= line_in;
         color_ff     <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff    <= s1_op_in;
      s1_color_ff <= s1_color_in;
      s1_line_ff  <= s1_line_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_emit_gives_pixel: assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |=> rsp_valid_ff)
      else $error("processed request produced no pixel");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (advance && emit && step_last) |=> !active_ff)
      else $error("line still active after its last pixel");

   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (line_ff.pixels_left == '0))
      else $error("pixels left with no line in progress");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |-> !req_ready)
      else $error("request taken while request stage is blocked");

endmodule

`default_nettype wire

@@ hdl/bres_setup.sv @@
// Line setup: step signs, doubled deltas, major axis and initial error.
`default_nettype none

module bres_setup (
   input  wire logic [bres_pkg::COORD_BITS-1:0] x0,
   input  wire logic [bres_pkg::COORD_BITS-1:0] y0,
   input  wire logic [bres_pkg::COORD_BITS-1:0] x1,
   input  wire logic [bres_pkg::COORD_BITS-1:0] y1,
   output bres_pkg::line_type                  line
);
   import bres_pkg::*;

   logic [COORD_BITS-1:0] abs_dx;
   logic [COORD_BITS-1:0] abs_dy;
   logic [COORD_BITS:0]   twice_dx;
   logic [COORD_BITS:0]   twice_dy;
   logic                  x_neg;
   logic                  y_neg;
   logic                  y_major;

   always_comb begin
      x_neg    = (x1 < x0);
      y_neg    = (y1 < y0);
      abs_dx   = x_neg ? (x0 - x1) : (x1 - x0);
      abs_dy   = y_neg ? (y0 - y1) : (y1 - y0);
      twice_dx = {abs_dx, 1'b0};
      twice_dy = {abs_dy, 1'b0};
      // y wins ties
      y_major  = !(abs_dx > abs_dy);

      line.cur_x      = x0;
      line.cur_y      = y0;
      line.x_negative = x_neg;
      line.y_negative = y_neg;
      line.y_major    = y_major;
      line.twice_dx   = twice_dx;
      line.twice_dy   = twice_dy;
      if (y_major) begin
         line.err_acc     = ERR_BITS'(twice_dx) - ERR_BITS'(abs_dy);
         line.pixels_left = abs_dy;
      end else begin
         line.err_acc     = ERR_BITS'(twice_dy) - ERR_BITS'(abs_dx);
         line.pixels_left = abs_dx;
      end
   end

endmodule

`default_nettype wire

@@ hdl/bres_step.sv @@
// One Bresenham step: flag the last pixel and advance position and error.
`default_nettype none

module bres_step (
   input  wire bres_pkg::line_type cur,
   output bres_pkg::line_type      nxt,
   output logic                    last
);
   import bres_pkg::*;

   logic                  err_ge;
   logic [COORD_BITS:0]   twice_major;
   logic [COORD_BITS:0]   twice_minor;
   logic [ERR_BITS-1:0]   err_sub;
   logic                  step_x;
   logic                  step_y;

   always_comb begin
      last        = (cur.pixels_left == '0);
      err_ge      = !cur.err_acc[ERR_BITS-1];
      twice_major = cur.y_major ? cur.twice_dy : cur.twice_dx;
      twice_minor = cur.y_major ? cur.twice_dx : cur.twice_dy;
      err_sub     = err_ge ? ERR_BITS'(twice_major) : '0;
      // major axis always steps, minor axis only when the error is nonnegative
      step_x      = cur.y_major ? err_ge : 1'b1;
      step_y      = cur.y_major ? 1'b1 : err_ge;

      nxt             = cur;
      nxt.err_acc     = cur.err_acc - err_sub + ERR_BITS'(twice_minor);
      if (step_x) begin
         nxt.cur_x = cur.x_negative ? (cur.cur_x - 1'b1) : (cur.cur_x + 1'b1);
      end
      if (step_y) begin
         nxt.cur_y = cur.y_negative ? (cur.cur_y - 1'b1) : (cur.cur_y + 1'b1);
      end
      if (!last) begin
         nxt.pixels_left = cur.pixels_left - 1'b1;
      end
   end

endmodule

`default_nettype wire

@@ dv/bresenham_line_pixel_generator_tb.sv @@
// Self-checking testbench for the Bresenham line pixel generator.
`timescale 1ns / 100ps

module bresenham_line_pixel_generator_tb;
   import bres_pkg::*;

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic [COORD_BITS:0]        twice_type;
   typedef logic signed [ERR_BITS-1:0] err_type;

   // How a directed row is checked: by the line walk, by a typed pixel, or no pixel.
   typedef enum logic [1:0] {ROW_PREDICT, ROW_PIXEL, ROW_SILENT} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      req_type      req;
      rsp_type      px;
   } row_type;

   localparam rsp_type NO_PX      = '0;
   localparam req_type NEXT_ONES  = '{OP_NEXT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
   localparam req_type NEXT_ZEROS = '{OP_NEXT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
   localparam int      NUM_ROWS   = 25;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   int      req_idle_pct = 29;
   int      rsp_idle_pct = 48;
   int      error_count = 0;
   rsp_type pixel_q[$];

   // Line walk state of the predictor
   coord_type walk_x = '0;
   coord_type walk_y = '0;
   err_type   walk_err = '0;
   coord_type walk_left = '0;
   bit        walk_xneg = 1'b0;
   bit        walk_yneg = 1'b0;
   bit        walk_ymajor = 1'b0;
   twice_type walk_2dx = '0;
   twice_type walk_2dy = '0;
   coord_type walk_color = '0;
   bit        walk_active = 1'b0;

   row_type directed_rows [NUM_ROWS] = '{
      '{ROW_SILENT, NEXT_ONES, NO_PX},
      '{ROW_PIXEL, '{OP_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF},
         '{16'h0000, 16'h0000, 16'hFFFF, 1'b1}},
      '{ROW_SILENT, NEXT_ZEROS, NO_PX},
      '{ROW_PIXEL, '{OP_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000},
         '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b1}},
      '{ROW_PIXEL, '{OP_START, 16'd10, 16'd20, 16'd15, 16'd22, 16'hF800},
         '{16'd10, 16'd20, 16'hF800, 1'b0}},
      '{ROW_PREDICT, NEXT_ONES, NO_PX},
      '{ROW_PREDICT, NEXT_ZEROS, NO_PX},
      '{ROW_PREDICT, NEXT_ONES, NO_PX},
      '{ROW_PREDICT, NEXT_ZEROS, NO_PX},
      '{ROW_PREDICT, NEXT_ONES, NO_PX},
      '{ROW_SILENT, NEXT_ZEROS, NO_PX},
      '{ROW_PIXEL, '{OP_START, 16'd100, 16'd100, 16'd97, 16'd90, 16'h07E0},
         '{16'd100, 16'd100, 16'h07E0, 1'b0}},
      '{ROW_PREDICT, NEXT_ONES, NO_PX},
      '{ROW_PREDICT, NEXT_ZEROS, NO_PX},
      '{ROW_PIXEL, '{OP_START, 16'd0, 16'd0, 16'd3, 16'd3, 16'h001F},
         '{16'd0, 16'd0, 16'h001F, 1'b0}},
      '{ROW_PREDICT, NEXT_ONES, NO_PX},
      '{ROW_PREDICT, NEXT_ZEROS, NO_PX},
      '{ROW_PREDICT, NEXT_ONES, NO_PX},
      '{ROW_PIXEL, '{OP_START, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'hAAAA},
         '{16'h0000, 16'h0000, 16'hAAAA, 1'b0}},
      '{ROW_PREDICT, NEXT_ZEROS, NO_PX},
      '{ROW_PREDICT, NEXT_ONES, NO_PX},
      '{ROW_PIXEL, '{OP_START, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h5555},
         '{16'hFFFF, 16'h0000, 16'h5555, 1'b0}},
      '{ROW_PREDICT, NEXT_ZEROS, NO_PX},
      '{ROW_PIXEL, '{OP_START, 16'h0007, 16'hFFFF, 16'h0007, 16'h0000, 16'h1234},
         '{16'h0007, 16'hFFFF, 16'h1234, 1'b0}},
      '{ROW_PREDICT, NEXT_ONES, NO_PX}
   };

   bresenham_line_pixel_generator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #4 clock = ~clock;

   function automatic coord_type advance_coord(input coord_type v, input bit down);
      return down ? v - 1'b1 : v + 1'b1;
   endfunction

   // Walk the line one request further; return 1 when a pixel comes out.
   function automatic bit walk_request(input req_type r, output rsp_type px);
      int dx;
      int dy;
      px = '0;
      if (r.op == OP_START) begin
         dx = int'(r.x_end) - int'(r.x_start);
         dy = int'(r.y_end) - int'(r.y_start);
         walk_xneg = (dx < 0);
         walk_yneg = (dy < 0);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         walk_2dx = twice_type'(2 * dx);
         walk_2dy = twice_type'(2 * dy);
         walk_ymajor = !(dx > dy);
         walk_err = walk_ymajor ? err_type'(2 * dx - dy) : err_type'(2 * dy - dx);
         walk_left = coord_type'(walk_ymajor ? dy : dx);
         walk_x = r.x_start;
         walk_y = r.y_start;
         walk_color = r.color;
      end else if (!walk_active) begin
         return 1'b0;
      end
      px.pixel_x = walk_x;
      px.pixel_y = walk_y;
      px.pixel_color = walk_color;
      px.last = (walk_left == 0);
      if (walk_ymajor) begin
         if (walk_err >= 0) begin
            walk_err = walk_err - err_type'(walk_2dy);
            walk_x = advance_coord(walk_x, walk_xneg);
         end
         walk_err = walk_err + err_type'(walk_2dx);
         walk_y = advance_coord(walk_y, walk_yneg);
      end else begin
         if (walk_err >= 0) begin
            walk_err = walk_err - err_type'(walk_2dx);
            walk_y = advance_coord(walk_y, walk_yneg);
         end
         walk_err = walk_err + err_type'(walk_2dy);
         walk_x = advance_coord(walk_x, walk_xneg);
      end
      if (px.last) begin
         walk_active = 1'b0;
      end else begin
         walk_left = walk_left - 1'b1;
         walk_active = 1'b1;
      end
      return 1'b1;
   endfunction

   // Hold the request until accepted, then queue what it should produce.
   task automatic send_request(input req_type r, input row_kind_type kind = ROW_PREDICT,
                               input rsp_type typed_px = '0);
      rsp_type px;
      bit      has_px;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      has_px = walk_request(r, px);
      case (kind)
         ROW_PREDICT: if (has_px) pixel_q.push_back(px);
         ROW_PIXEL:   pixel_q.push_back(typed_px);
         default:     ;
      endcase
   endtask

   function automatic req_type random_request(input logic op);
      req_type r;
      r.op = op;
      r.x_start = coord_type'($urandom);
      r.y_start = coord_type'($urandom);
      r.x_end = coord_type'($urandom);
      r.y_end = coord_type'($urandom);
      r.color = coord_type'($urandom);
      return r;
   endfunction

   function automatic coord_type random_coord();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Pick an endpoint within span of base without leaving the coordinate range.
   function automatic coord_type near_coord(input coord_type base, input int span);
      int d;
      d = $urandom_range(span);
      if ($urandom_range(1)) begin
         return (int'(base) + d > 16'hFFFF) ? coord_type'(int'(base) - d)
                                            : coord_type'(int'(base) + d);
      end
      return (int'(base) < d) ? coord_type'(int'(base) + d) : coord_type'(int'(base) - d);
   endfunction

   task automatic run_random(input int n_items);
      int      sent;
      int      steps;
      req_type r;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 6) begin
            if (walk_active) sent++;
            send_request(random_request(OP_NEXT));
         end else begin
            r = random_request(OP_START);
            r.x_start = random_coord();
            r.y_start = random_coord();
            case ($urandom_range(19))
               0: ;
               1: begin
                  r.x_end = r.x_start;
                  r.y_end = r.y_start;
               end
               2: begin
                  r.x_end = near_coord(r.x_start, 30);
                  r.y_end = r.y_start;
               end
               3: begin
                  r.x_end = r.x_start;
                  r.y_end = near_coord(r.y_start, 30);
               end
               default: begin
                  r.x_end = near_coord(r.x_start, 24);
                  r.y_end = near_coord(r.y_start, 24);
               end
            endcase
            send_request(r);
            sent++;
            steps = walk_active ? int'(walk_left) + 1 : 0;
            // Cut long lines short, abandon some lines early, overrun a few
            if (steps > 48) steps = $urandom_range(48);
            else if ($urandom_range(7) == 0) steps = $urandom_range(steps);
            if ($urandom_range(3) == 0) steps++;
            for (int i = 0; i < steps; i++) begin
               if (walk_active) sent++;
               send_request(random_request(OP_NEXT));
            end
         end
      end
   endtask

   task automatic check_pixel(input rsp_type got);
      rsp_type want;
      if (pixel_q.size() == 0) begin
         $display("%0t: unexpected pixel x=%h y=%h color=%h last=%b", $time,
                  got.pixel_x, got.pixel_y, got.pixel_color, got.last);
         error_count++;
      end else begin
         want = pixel_q.pop_front();
         if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
             got.pixel_color !== want.pixel_color || got.last !== want.last) begin
            $display("%0t: expected x=%h y=%h color=%h last=%b, got x=%h y=%h color=%h last=%b",
                     $time, want.pixel_x, want.pixel_y, want.pixel_color, want.last,
                     got.pixel_x, got.pixel_y, got.pixel_color, got.last);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_pixel(rsp_payload);
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < NUM_ROWS; i++)
         send_request(directed_rows[i].req, directed_rows[i].kind, directed_rows[i].px);
      run_random(500);
      req_idle_pct = 48;
      rsp_idle_pct = 29;
      run_random(500);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(500);
      req_valid <= 1'b0;
      for (int i = 0; i < 20000 && pixel_q.size() != 0; i++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (pixel_q.size() != 0) begin
         $display("%0t: %0d pixels never arrived", $time, pixel_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("bresenham_line_pixel_generator_tb: clean");
      end else begin
         $display("bresenham_line_pixel_generator_tb: errors");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("bresenham_line_pixel_generator_tb: errors");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/bres_pkg.sv
hdl/bres_setup.sv
hdl/bres_step.sv
hdl/bresenham_line_pixel_generator.sv
dv/bresenham_line_pixel_generator_tb.sv
